FILE: hw/rtl/itp_pkg.sv
`timescale 1ns / 1ps

package itp_pkg;

  localparam logic [7:0] SYM_LPAREN = 8'h28;
  localparam logic [7:0] SYM_RPAREN = 8'h29;
  localparam logic [7:0] SYM_CARET  = 8'h5E;
  localparam logic [7:0] SYM_STAR   = 8'h2A;
  localparam logic [7:0] SYM_SLASH  = 8'h2F;
  localparam logic [7:0] SYM_PLUS   = 8'h2B;
  localparam logic [7:0] SYM_MINUS  = 8'h2D;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNMATCH  = 2'd2;

  typedef enum logic [1:0] {
    CLS_OPERAND,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_OPER
  } sym_class_t;

  typedef enum logic [1:0] {
    SRC_CUR,
    SRC_TOP,
    SRC_ERR_OVF,
    SRC_ERR_PAREN
  } emit_src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_FRD,
    ST_FCMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      ld;
    logic      push;
    logic      pop;
    logic      clear;
    logic      emit;
    emit_src_t emit_src;
    logic      finish;
  } ctl_cmd_t;

  typedef struct packed {
    sym_class_t in_class;
    logic       in_fin;
    sym_class_t cur_class;
    logic [1:0] cur_prec;
    logic [1:0] top_prec;
    logic       top_lparen;
    logic       cnt_zero;
    logic       cnt_one;
    logic       full;
    logic       out_space;
    logic       cur_fin;
  } dp_stat_t;

  typedef struct packed {
    logic [7:0] sym;
    logic       has;
    logic [1:0] err;
  } result_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == SYM_CARET) p = 2'd3;
    else if (c == SYM_STAR || c == SYM_SLASH) p = 2'd2;
    else if (c == SYM_PLUS || c == SYM_MINUS) p = 2'd1;
    return p;
  endfunction

  function automatic sym_class_t class_of(input logic [7:0] c);
    sym_class_t k;
    k = CLS_OPERAND;
    if (c == SYM_LPAREN) k = CLS_LPAREN;
    else if (c == SYM_RPAREN) k = CLS_RPAREN;
    else if (prec_of(c) != 2'd0) k = CLS_OPER;
    return k;
  endfunction

endpackage

FILE: hw/rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// An operand of a non-final character is emitted straight from ST_IDLE; an operator or
// ')' goes through ST_RD and ST_CMP, and again per operator popped. A final character
// then flushes each stacked entry through ST_FRD and ST_FCMP; ST_DONE gives the end
// result. Input is taken only in ST_IDLE. Synchronous active-low reset empties the
// stack and the output register; stack memory contents are not cleared.

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       in_final_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       out_has_symbol,
  output logic       out_end_of_expr,
  output logic [1:0] out_error_code
);

  import itp_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  itp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  itp_datapath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_symbol      (in_symbol),
    .in_final_char  (in_final_char),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_has_symbol (out_has_symbol),
    .out_end_of_expr(out_end_of_expr),
    .out_error_code (out_error_code)
  );

endmodule

FILE: hw/rtl/itp_ram.sv
`timescale 1ns / 1ps

module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/itp_datapath.sv
`timescale 1ns / 1ps

module itp_datapath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_symbol,
  input  logic            in_final_char,
  input  itp_pkg::ctl_cmd_t cmd,
  output itp_pkg::dp_stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_symbol,
  output logic            out_has_symbol,
  output logic            out_end_of_expr,
  output logic [1:0]      out_error_code
);

  import itp_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        sym_r;
  logic              fin_r;
  logic [7:0]        cur_sym;
  logic              cur_fin;
  logic [7:0]        top_sym;
  logic [CNT_W-1:0]  top_idx;
  result_t           hold_r, hold_nxt;
  logic              hold_v_r, hold_v_nxt;
  result_t           out_r, out_nxt;
  logic              out_end_r, out_end_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_space;
  result_t           emit_res;

  assign cur_sym = cmd.ld ? in_symbol : sym_r;
  assign cur_fin = cmd.ld ? in_final_char : fin_r;
  assign top_idx = cnt_r - CNT_W'(1);

  itp_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(cnt_r[ADDR_W-1:0]),
    .wdata(cur_sym),
    .raddr(top_idx[ADDR_W-1:0]),
    .rdata(top_sym)
  );

  assign out_space = !out_valid_r || out_ready;

  // Status is taken from the ports and registers only, never from the commands.
  always_comb begin
    stat.in_class   = class_of(in_symbol);
    stat.in_fin     = in_final_char;
    stat.cur_class  = class_of(sym_r);
    stat.cur_prec   = prec_of(sym_r);
    stat.top_prec   = prec_of(top_sym);
    stat.top_lparen = (top_sym == SYM_LPAREN);
    stat.cnt_zero   = (cnt_r == '0);
    stat.cnt_one    = (cnt_r == CNT_W'(1));
    stat.full       = (cnt_r == CNT_W'(STACK_DEPTH));
    stat.out_space  = out_space;
    stat.cur_fin    = fin_r;
  end

  always_comb begin
    case (cmd.emit_src)
      SRC_CUR:       emit_res = '{sym: cur_sym, has: 1'b1, err: ERR_NONE};
      SRC_TOP:       emit_res = '{sym: top_sym, has: 1'b1, err: ERR_NONE};
      SRC_ERR_OVF:   emit_res = '{sym: 8'h00, has: 1'b0, err: ERR_OVERFLOW};
      SRC_ERR_PAREN: emit_res = '{sym: 8'h00, has: 1'b0, err: ERR_UNMATCH};
      default:       emit_res = '{sym: 8'h00, has: 1'b0, err: ERR_NONE};
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Results of a final item are held back by one so that the last one can
  // carry the end mark.
  always_comb begin
    hold_nxt      = hold_r;
    hold_v_nxt    = hold_v_r;
    out_nxt       = out_r;
    out_end_nxt   = out_end_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      if (!cur_fin) begin
        out_nxt       = emit_res;
        out_end_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        if (hold_v_r) begin
          out_nxt       = hold_r;
          out_end_nxt   = 1'b0;
          out_valid_nxt = 1'b1;
        end
        hold_nxt   = emit_res;
        hold_v_nxt = 1'b1;
      end
    end else if (cmd.finish) begin
      out_nxt       = hold_v_r ? hold_r : result_t'{sym: 8'h00, has: 1'b0, err: ERR_NONE};
      out_end_nxt   = 1'b1;
      out_valid_nxt = 1'b1;
      hold_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      sym_r <= in_symbol;
      fin_r <= in_final_char;
    end
    hold_r    <= hold_nxt;
    out_r     <= out_nxt;
    out_end_r <= out_end_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_r.sym;
  assign out_has_symbol  = out_r.has;
  assign out_error_code  = out_r.err;
  assign out_end_of_expr = out_end_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_hold_fin: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r |-> fin_r)
    else $error("held result outside a final item");

  a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.finish) |-> out_space)
    else $error("result written while output register is occupied");

endmodule

FILE: hw/rtl/itp_ctrl.sv
`timescale 1ns / 1ps

module itp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itp_pkg::dp_stat_t stat,
  output itp_pkg::ctl_cmd_t cmd
);

  import itp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.emit_src = SRC_CUR;
    case (state_r)
      ST_IDLE: begin
        in_ready = stat.out_space;
        if (in_valid && stat.out_space) begin
          cmd.ld = 1'b1;
          case (stat.in_class)
            CLS_OPERAND: begin
              cmd.emit     = 1'b1;
              cmd.emit_src = SRC_CUR;
              if (stat.in_fin) begin
                state_nxt = stat.cnt_zero ? ST_DONE : ST_FRD;
              end
            end
            CLS_LPAREN: begin
              if (stat.full) begin
                cmd.clear    = 1'b1;
                cmd.emit     = 1'b1;
                cmd.emit_src = SRC_ERR_OVF;
                if (stat.in_fin) begin
                  state_nxt = ST_DONE;
                end
              end else begin
                cmd.push = 1'b1;
                if (stat.in_fin) begin
                  state_nxt = ST_FRD;
                end
              end
            end
            default: begin
              state_nxt = ST_RD;
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.cur_class == CLS_RPAREN) begin
          if (stat.cnt_zero) begin
            if (stat.out_space) begin
              cmd.emit     = 1'b1;
              cmd.emit_src = SRC_ERR_PAREN;
              state_nxt    = stat.cur_fin ? ST_DONE : ST_IDLE;
            end
          end else if (stat.top_lparen) begin
            cmd.pop = 1'b1;
            if (stat.cur_fin) begin
              state_nxt = stat.cnt_one ? ST_DONE : ST_FRD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else if (stat.out_space) begin
            cmd.emit     = 1'b1;
            cmd.emit_src = SRC_TOP;
            cmd.pop      = 1'b1;
            state_nxt    = ST_RD;
          end
        end else begin
          // Pop while the stacked operator binds at least as tightly.
          if (!stat.cnt_zero && stat.top_prec >= stat.cur_prec) begin
            if (stat.out_space) begin
              cmd.emit     = 1'b1;
              cmd.emit_src = SRC_TOP;
              cmd.pop      = 1'b1;
              state_nxt    = ST_RD;
            end
          end else if (stat.full) begin
            if (stat.out_space) begin
              cmd.clear    = 1'b1;
              cmd.emit     = 1'b1;
              cmd.emit_src = SRC_ERR_OVF;
              state_nxt    = stat.cur_fin ? ST_DONE : ST_IDLE;
            end
          end else begin
            cmd.push  = 1'b1;
            state_nxt = stat.cur_fin ? ST_FRD : ST_IDLE;
          end
        end
      end
      ST_FRD: begin
        state_nxt = ST_FCMP;
      end
      ST_FCMP: begin
        // An unmatched open parenthesis is discarded without a result.
        if (stat.top_lparen) begin
          cmd.pop   = 1'b1;
          state_nxt = stat.cnt_one ? ST_DONE : ST_FRD;
        end else if (stat.out_space) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = SRC_TOP;
          cmd.pop      = 1'b1;
          state_nxt    = stat.cnt_one ? ST_DONE : ST_FRD;
        end
      end
      ST_DONE: begin
        if (stat.out_space) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE))
    else $error("input taken outside idle");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !stat.full)
    else $error("push onto a full stack");

  a_emit_top: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_src == SRC_TOP) |-> (!stat.top_lparen && !stat.cnt_zero))
    else $error("emitted an open parenthesis or popped an empty stack");

endmodule

FILE: bench/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import itp_pkg::*;

  localparam int STACK_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;

  localparam logic [7:0] OPERATOR_SET [0:4] = '{SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH,
                                                SYM_CARET};
  localparam logic [7:0] SPECIAL_SET [0:6] = '{SYM_PLUS, SYM_MINUS, SYM_STAR, SYM_SLASH,
                                               SYM_CARET, SYM_LPAREN, SYM_RPAREN};

  typedef struct packed {
    logic [7:0] sym;
    logic       has;
    logic       last;
    logic [1:0] err;
  } postfix_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_symbol;
  logic       in_final_char;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_symbol;
  logic       out_has_symbol;
  logic       out_end_of_expr;
  logic [1:0] out_error_code;

  // Model of the operator stack, kept in step with accepted transactions.
  logic [7:0]      op_stack [0:63];
  int              op_depth;
  postfix_result_t pending_results[$];
  logic [7:0]      expr_buf[$];

  int mismatches;
  int items_sent;
  int results_checked;
  int overflows_seen;
  int unmatched_seen;
  bit in_gaps_on;
  bit out_gaps_on;
  bit hold_output;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_final_char  (in_final_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_has_symbol (out_has_symbol),
    .out_end_of_expr(out_end_of_expr),
    .out_error_code (out_error_code)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int op_rank(input logic [7:0] c);
    case (c)
      SYM_CARET:           return 3;
      SYM_STAR, SYM_SLASH: return 2;
      SYM_PLUS, SYM_MINUS: return 1;
      default:             return 0;
    endcase
  endfunction

  function automatic logic [7:0] random_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (op_rank(c) != 0 || c == SYM_LPAREN || c == SYM_RPAREN);
    return c;
  endfunction

  function automatic void queue_result(input logic [7:0] sym, input logic has,
                                       input logic [1:0] err);
    postfix_result_t r;
    r.sym  = sym;
    r.has  = has;
    r.last = 1'b0;
    r.err  = err;
    pending_results.push_back(r);
  endfunction

  function automatic void push_or_overflow(input logic [7:0] sym);
    if (op_depth >= STACK_DEPTH) begin
      op_depth = 0;
      queue_result(8'h00, 1'b0, ERR_OVERFLOW);
    end else begin
      op_stack[op_depth] = sym;
      op_depth++;
    end
  endfunction

  function automatic void convert_symbol(input logic [7:0] sym, input logic fin);
    int              queued_before;
    bit              matched;
    logic [7:0]      t;
    postfix_result_t r;
    queued_before = pending_results.size();
    if (sym == SYM_LPAREN) begin
      push_or_overflow(sym);
    end else if (sym == SYM_RPAREN) begin
      matched = 1'b0;
      while (op_depth > 0 && !matched) begin
        op_depth--;
        t = op_stack[op_depth];
        if (t == SYM_LPAREN) matched = 1'b1;
        else queue_result(t, 1'b1, ERR_NONE);
      end
      if (!matched) queue_result(8'h00, 1'b0, ERR_UNMATCH);
    end else if (op_rank(sym) != 0) begin
      while (op_depth > 0 && op_rank(op_stack[op_depth - 1]) >= op_rank(sym)) begin
        op_depth--;
        queue_result(op_stack[op_depth], 1'b1, ERR_NONE);
      end
      push_or_overflow(sym);
    end else begin
      queue_result(sym, 1'b1, ERR_NONE);
    end
    if (fin) begin
      // Leftover open parentheses vanish without a result.
      while (op_depth > 0) begin
        op_depth--;
        if (op_stack[op_depth] != SYM_LPAREN) queue_result(op_stack[op_depth], 1'b1, ERR_NONE);
      end
      if (pending_results.size() == queued_before) queue_result(8'h00, 1'b0, ERR_NONE);
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH on result %0d: %s", $realtime, results_checked, msg);
    mismatches++;
  endtask

  task automatic send_symbol(input logic [7:0] sym, input logic fin);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_symbol     <= sym;
    in_final_char <= fin;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    convert_symbol(sym, fin);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_symbol(s[i], i == s.len() - 1);
  endtask

  task automatic send_expression(input bit fin_at_end);
    for (int i = 0; i < expr_buf.size(); i++)
      send_symbol(expr_buf[i], fin_at_end && i == expr_buf.size() - 1);
  endtask

  // Mostly balanced expressions; now and then a missing or a surplus ')'.
  task automatic build_well_formed();
    int opens;
    int terms;
    expr_buf.delete();
    opens = 0;
    terms = $urandom_range(1, 7);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) expr_buf.push_back(OPERATOR_SET[$urandom_range(0, 4)]);
      while ($urandom_range(0, 3) == 0 && opens < 8) begin
        expr_buf.push_back(SYM_LPAREN);
        opens++;
      end
      expr_buf.push_back(random_operand());
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        expr_buf.push_back(SYM_RPAREN);
        opens--;
      end
    end
    case ($urandom_range(0, 9))
      0: ;
      1: expr_buf.push_back(SYM_RPAREN);
      default: repeat (opens) expr_buf.push_back(SYM_RPAREN);
    endcase
  endtask

  task automatic build_noise();
    expr_buf.delete();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 1) != 0) expr_buf.push_back(8'($urandom_range(0, 255)));
      else expr_buf.push_back(SPECIAL_SET[$urandom_range(0, 6)]);
    end
  endtask

  task automatic test_directed_cases();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    send_text("a+b*c");
    // Equal precedence pops, so power is left associative here.
    send_text("x^y^z-(u/w)");
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_symbol(SYM_RPAREN, 1'b0);
    // A lone open parenthesis produces nothing, so only the bare end marker comes out.
    send_symbol(SYM_LPAREN, 1'b1);
    send_symbol(SYM_PLUS, 1'b1);
    send_text("k*m)");
  endtask

  task automatic test_stack_overflow();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b1;
    repeat (STACK_DEPTH + 1) send_symbol(SYM_LPAREN, 1'b0);
    send_symbol(8'h61, 1'b1);
    repeat (STACK_DEPTH) send_symbol(SYM_LPAREN, 1'b0);
    send_symbol(SYM_PLUS, 1'b1);
  endtask

  task automatic test_output_backpressure();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    hold_output = 1'b1;
    repeat (4) begin
      build_well_formed();
      send_expression(1'b1);
    end
  endtask

  task automatic test_random_expressions();
    int sent_here;
    int expr_count;
    sent_here  = 0;
    expr_count = 0;
    while (sent_here < RANDOM_ITEMS) begin
      if (expr_count % 8 == 0) begin
        in_gaps_on  = ($urandom_range(0, 3) != 0);
        out_gaps_on = ($urandom_range(0, 3) != 0);
      end
      expr_count++;
      if ($urandom_range(0, 3) != 0) begin
        build_well_formed();
        send_expression(1'b1);
      end else begin
        build_noise();
        send_expression($urandom_range(0, 3) != 0);
      end
      sent_here += expr_buf.size();
    end
  endtask

  always @(posedge clk) begin
    postfix_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_error_code == ERR_OVERFLOW) overflows_seen++;
      if (out_error_code == ERR_UNMATCH) unmatched_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (out_symbol !== want.sym)
          report_mismatch($sformatf("out_symbol %h, wanted %h", out_symbol, want.sym));
        if (out_has_symbol !== want.has)
          report_mismatch($sformatf("out_has_symbol %b, wanted %b", out_has_symbol, want.has));
        if (out_end_of_expr !== want.last)
          report_mismatch($sformatf("out_end_of_expr %b, wanted %b", out_end_of_expr,
                                    want.last));
        if (out_error_code !== want.err)
          report_mismatch($sformatf("out_error_code %0d, wanted %0d", out_error_code,
                                    want.err));
      end
      results_checked++;
    end
  end

  // Output side: a random pause before each transaction, or one long hold on request.
  initial begin : receiver
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_output) begin
        gap = HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        gap = out_gaps_on ? $urandom_range(0, 13) : 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] no transaction for %0d cycles", $realtime, QUIET_LIMIT);
    $display("infix_to_postfix_converter verification failed");
    $finish;
  end

  initial begin
    mismatches      = 0;
    items_sent      = 0;
    results_checked = 0;
    overflows_seen  = 0;
    unmatched_seen  = 0;
    op_depth        = 0;
    hold_output     = 1'b0;
    in_gaps_on      = 1'b0;
    out_gaps_on     = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_symbol     <= 8'h00;
    in_final_char <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_stack_overflow();
    test_output_backpressure();
    test_random_expressions();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters and checked %0d postfix results, with %0d overflow", items_sent,
             results_checked, overflows_seen);
    $display("and %0d unmatched-parenthesis errors, under random stalls and a long output hold.",
             unmatched_seen);
    if (mismatches == 0) begin
      $display("infix_to_postfix_converter verification clean");
    end else begin
      $display("infix_to_postfix_converter verification failed");
    end
    $finish;
  end

endmodule
